// ===== rtl/polynomial_value_conversion_defines.svh =====
// Assertion macros shared by the polynomial conversion RTL.
`ifndef POLYNOMIAL_VALUE_CONVERSION_DEFINES_SVH
`define POLYNOMIAL_VALUE_CONVERSION_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is held.
`define PVC_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pvc assertion failed");

// Next-cycle implication, disabled while reset is held.
`define PVC_ASSERT_NXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pvc assertion failed");

`else

`define PVC_ASSERT_IMP(name, clk, rst_n, pre, post)
`define PVC_ASSERT_NXT(name, clk, rst_n, pre, post)

`endif

`endif

// ===== rtl/pvc_pkg.sv =====
// Shared types and constants for the polynomial value conversion pipeline.
package pvc_pkg;

    localparam int unsigned NUM_COEFFS = 7;

    typedef logic [2:0] t_count;
    typedef logic [2:0] t_reg_idx;

    // Register map, one 32-bit word per register
    localparam t_reg_idx REG_COEFF_COUNT = 3'd0;
    localparam t_reg_idx REG_COEFF_0     = 3'd1;

    localparam t_count            COUNT_RESET = 3'd2;
    localparam logic signed [31:0] COEFF_ONE  = 32'sh0001_0000;

    localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

    // One item in flight through the term chain
    typedef struct packed {
        logic               valid;
        logic signed [31:0] x;
        logic signed [63:0] power;
        logic signed [63:0] acc;
        logic               sat;
    } t_lane;

endpackage

// ===== rtl/pvc_mul.sv =====
// Two-stage 64x32 signed multiply, arithmetic shift right and saturation to 64 bits.
module pvc_mul #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_p,
    output logic               o_ovf
);

    logic signed [64:0] r_pp_lo;
    logic signed [63:0] r_pp_hi;
    logic signed [96:0] w_full;
    logic signed [96:0] w_shift;
    logic        [33:0] w_top;
    logic               w_ovf;
    logic signed [63:0] r_p;
    logic               r_ovf;

    // Stage 1: low half is taken unsigned, high half carries the sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp_lo <= $signed({1'b0, i_a[31:0]}) * i_b;
            r_pp_hi <= $signed(i_a[63:32]) * i_b;
        end
    end

    assign w_full  = $signed({r_pp_hi[63], r_pp_hi, 32'd0})
                   + $signed({{32{r_pp_lo[64]}}, r_pp_lo});
    assign w_shift = w_full >>> FRAC_BITS;
    assign w_top   = w_shift[96:63];
    assign w_ovf   = !((&w_top) || !(|w_top));

    // Stage 2: floor shift done, clamp to the signed 64-bit range
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf <= w_ovf;
            if (w_ovf) begin
                r_p <= w_shift[96] ? pvc_pkg::SAT_MIN : pvc_pkg::SAT_MAX;
            end else begin
                r_p <= w_shift[63:0];
            end
        end
    end

    assign o_p   = r_p;
    assign o_ovf = r_ovf;

endmodule

// ===== rtl/pvc_term.sv =====
// One polynomial term: power update, coefficient product and saturating accumulate.
`include "polynomial_value_conversion_defines.svh"

module pvc_term #(
    parameter int unsigned TERM_IDX  = 1,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  pvc_pkg::t_lane     i_lane,
    input  logic signed [31:0] i_coeff,
    input  pvc_pkg::t_count   i_terms,
    output pvc_pkg::t_lane     o_lane
);

    pvc_pkg::t_lane r_s1, r_s2, r_s3, r_s4, r_s5;
    pvc_pkg::t_lane n_s3, n_s5;

    logic               w_active;
    logic signed [63:0] w_pow_p;
    logic               w_pow_ovf;
    logic signed [63:0] w_pow;
    logic signed [63:0] w_term;
    logic               w_term_ovf;
    logic signed [63:0] w_sum;
    logic               w_add_ovf;

    // Terms at or beyond the coefficient count pass the item through untouched
    assign w_active = pvc_pkg::t_count'(TERM_IDX) < i_terms;

    pvc_mul #(.FRAC_BITS(FRAC_BITS)) u_pow_mul (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_lane.power),
        .i_b   (i_lane.x),
        .o_p   (w_pow_p),
        .o_ovf (w_pow_ovf)
    );

    assign w_pow = w_active ? w_pow_p : r_s2.power;

    always_comb begin
        n_s3       = r_s2;
        n_s3.power = w_pow;
        n_s3.sat   = r_s2.sat | (w_active & w_pow_ovf);
    end

    pvc_mul #(.FRAC_BITS(FRAC_BITS)) u_coeff_mul (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (w_pow),
        .i_b   (i_coeff),
        .o_p   (w_term),
        .o_ovf (w_term_ovf)
    );

    assign w_sum     = r_s4.acc + w_term;
    assign w_add_ovf = (r_s4.acc[63] == w_term[63]) && (w_sum[63] != r_s4.acc[63]);

    always_comb begin
        n_s5 = r_s4;
        if (w_active) begin
            if (w_add_ovf) begin
                n_s5.acc = r_s4.acc[63] ? pvc_pkg::SAT_MIN : pvc_pkg::SAT_MAX;
            end else begin
                n_s5.acc = w_sum;
            end
            n_s5.sat = r_s4.sat | w_term_ovf | w_add_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
            r_s4.valid <= 1'b0;
            r_s5.valid <= 1'b0;
        end else if (i_en) begin
            r_s1 <= i_lane;
            r_s2 <= r_s1;
            r_s3 <= n_s3;
            r_s4 <= r_s3;
            r_s5 <= n_s5;
        end
    end

    assign o_lane = r_s5;

    `PVC_ASSERT_NXT(a_idle_term_keeps_acc, i_clk, i_rst_n,
        i_en && r_s4.valid && !w_active, r_s5.acc == $past(r_s4.acc))
    `PVC_ASSERT_NXT(a_frozen_when_held, i_clk, i_rst_n, !i_en, $stable(r_s5))

endmodule

// ===== rtl/polynomial_value_conversion.sv =====
// Polynomial value conversion: raw Q16.16 sample to Q48.16 engineering value.
//
// Input channel: i_valid / o_stall with i_raw_value; a beat is taken on a clock edge
// with i_valid high and o_stall low. Output channel: o_valid / i_stall with
// o_converted_value and o_saturated. Coefficients are written over the APB port
// (count at 0x00, c0..c6 at 0x04..0x1C) and must only change while nothing is in flight.
//
// Each coefficient term is a five-stage slice (two multiply stages for the power,
// two for the coefficient product, one for the saturating add); MAX_TERMS-1 slices
// are chained. Each beat passes through every slice, then into the output register.
// One beat is taken per cycle while the output keeps flowing.
//
// The output register is backed by a one-entry skid register. When the receiver
// stalls, the beat leaving the chain parks in the skid register and the whole chain
// holds until the skid register drains; o_stall is that register's valid flag.
// Reset empties the chain and the output, sets the count to 2 and c1 to 1.0.
`include "polynomial_value_conversion_defines.svh"

module polynomial_value_conversion #(
    parameter int unsigned MAX_TERMS = 7,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_raw_value,
    // Output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [63:0] o_converted_value,
    output logic               o_saturated,
    // Configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [4:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);

    localparam logic signed [63:0] POWER_ONE = 64'sd1 <<< FRAC_BITS;

    pvc_pkg::t_count   r_count;
    logic signed [31:0] r_coeff [pvc_pkg::NUM_COEFFS];
    pvc_pkg::t_reg_idx w_reg_idx;
    pvc_pkg::t_count   w_terms;
    logic               w_advance;

    pvc_pkg::t_lane     w_lane [MAX_TERMS];
    pvc_pkg::t_lane     w_last;

    logic               r_out_valid;
    logic signed [63:0] r_out_value;
    logic               r_out_sat;
    logic               r_skid_valid;
    logic signed [63:0] r_skid_value;
    logic               r_skid_sat;

    // Configuration registers
    assign w_reg_idx = paddr[4:2];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= pvc_pkg::COUNT_RESET;
            for (int i = 0; i < pvc_pkg::NUM_COEFFS; i++) begin
                r_coeff[i] <= '0;
            end
            r_coeff[1] <= pvc_pkg::COEFF_ONE;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg_idx)
                pvc_pkg::REG_COEFF_COUNT: r_count <= pwdata[2:0];
                default: r_coeff[w_reg_idx - pvc_pkg::REG_COEFF_0] <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            pvc_pkg::REG_COEFF_COUNT: prdata = {29'd0, r_count};
            default: prdata = r_coeff[w_reg_idx - pvc_pkg::REG_COEFF_0];
        endcase
    end

    // A count of zero still yields c0; counts above the chain length are clipped
    always_comb begin
        w_terms = r_count;
        if (w_terms == '0) begin
            w_terms = pvc_pkg::t_count'(1);
        end
        if (w_terms > pvc_pkg::t_count'(MAX_TERMS)) begin
            w_terms = pvc_pkg::t_count'(MAX_TERMS);
        end
    end

    // Chain holds whenever a beat is parked in the skid register
    assign w_advance = !r_skid_valid;
    assign o_stall   = r_skid_valid;

    always_comb begin
        w_lane[0].valid = i_valid;
        w_lane[0].x     = i_raw_value;
        w_lane[0].power = POWER_ONE;
        w_lane[0].acc   = {{32{r_coeff[0][31]}}, r_coeff[0]};
        w_lane[0].sat   = 1'b0;
    end

    for (genvar k = 1; k < MAX_TERMS; k++) begin : g_term
        pvc_term #(
            .TERM_IDX  (k),
            .FRAC_BITS (FRAC_BITS)
        ) u_term (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_advance),
            .i_lane  (w_lane[k-1]),
            .i_coeff (r_coeff[k]),
            .i_terms (w_terms),
            .o_lane  (w_lane[k])
        );
    end

    assign w_last = w_lane[MAX_TERMS-1];

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (!i_stall) begin
                r_out_value  <= r_skid_value;
                r_out_sat    <= r_skid_sat;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid <= w_last.valid;
            r_out_value <= w_last.acc;
            r_out_sat   <= w_last.sat;
        end else if (w_last.valid) begin
            r_skid_valid <= 1'b1;
            r_skid_value <= w_last.acc;
            r_skid_sat   <= w_last.sat;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_converted_value = r_out_value;
    assign o_saturated       = r_out_sat;

    `PVC_ASSERT_IMP(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `PVC_ASSERT_NXT(a_skid_held, i_clk, i_rst_n, r_skid_valid && i_stall, r_skid_valid)

endmodule

// ===== tb/tb_polynomial_value_conversion.sv =====
// Self-checking testbench for the polynomial value conversion pipeline.
module tb_polynomial_value_conversion;

    localparam int FRAC_BITS   = 16;
    localparam int MAX_TERMS   = 7;
    localparam int LATENCY     = 5 * (MAX_TERMS - 1);
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 240;
    localparam int MAX_GAP     = 17;
    localparam int RAND_PHASES = 14;
    localparam int PHASE_ITEMS = 125;
    localparam int MAX_PRINTS  = 100;
    localparam int NUM_DIR     = 24;

    localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] C_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        SET_RESET, SET_COUNT_ZERO, SET_CONST_ONLY, SET_ALL_MAX, SET_ALL_MIN, SET_MIXED
    } t_coeff_set;

    typedef struct packed {
        logic signed [63:0] value;
        logic               sat;
    } t_conv;

    typedef struct packed {
        logic signed [31:0] raw;
        t_coeff_set         coeffs;
        logic               typed;
        logic signed [63:0] want_value;
        logic               want_sat;
    } t_dir_row;

    // Typed rows are plain arithmetic; the rest go through the predictor
    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        '{32'sh0000_0000, SET_RESET, 1'b1, 64'sh0000_0000_0000_0000, 1'b0},
        '{32'sh0000_0001, SET_RESET, 1'b1, 64'sh0000_0000_0000_0001, 1'b0},
        '{32'shFFFF_FFFF, SET_RESET, 1'b1, 64'shFFFF_FFFF_FFFF_FFFF, 1'b0},
        '{C_MAX,          SET_RESET, 1'b1, 64'sh0000_0000_7FFF_FFFF, 1'b0},
        '{C_MIN,          SET_RESET, 1'b1, 64'shFFFF_FFFF_8000_0000, 1'b0},
        '{32'sh0001_0000, SET_RESET, 1'b1, 64'sh0000_0000_0001_0000, 1'b0},
        '{32'shFFFF_0000, SET_RESET, 1'b1, 64'shFFFF_FFFF_FFFF_0000, 1'b0},
        '{32'sh5555_AAAA, SET_RESET, 1'b1, 64'sh0000_0000_5555_AAAA, 1'b0},
        '{32'shAAAA_5555, SET_RESET, 1'b1, 64'shFFFF_FFFF_AAAA_5555, 1'b0},
        '{C_MAX,          SET_COUNT_ZERO, 1'b1, 64'shFFFF_FFFF_8000_0000, 1'b0},
        '{C_MIN,          SET_COUNT_ZERO, 1'b1, 64'shFFFF_FFFF_8000_0000, 1'b0},
        '{32'sh1234_5678, SET_CONST_ONLY, 1'b1, 64'sh0000_0000_7FFF_FFFF, 1'b0},
        '{C_MAX,          SET_ALL_MAX, 1'b1, pvc_pkg::SAT_MAX,          1'b1},
        '{32'sh0000_0000, SET_ALL_MAX, 1'b1, 64'sh0000_0000_7FFF_FFFF, 1'b0},
        '{32'sh0001_0000, SET_ALL_MAX, 1'b1, 64'sh0000_0003_7FFF_FFF9, 1'b0},
        '{32'shFFFF_0000, SET_ALL_MAX, 1'b1, 64'sh0000_0000_7FFF_FFFF, 1'b0},
        '{C_MIN,          SET_ALL_MAX, 1'b0, 64'sh0, 1'b0},
        '{32'sh0001_0000, SET_ALL_MIN, 1'b1, 64'shFFFF_FFFC_8000_0000, 1'b0},
        '{C_MAX,          SET_ALL_MIN, 1'b0, 64'sh0, 1'b0},
        '{C_MIN,          SET_ALL_MIN, 1'b0, 64'sh0, 1'b0},
        '{32'sh0001_8000, SET_MIXED, 1'b0, 64'sh0, 1'b0},
        '{32'shFFFE_0000, SET_MIXED, 1'b0, 64'sh0, 1'b0},
        '{32'sh0000_0001, SET_MIXED, 1'b0, 64'sh0, 1'b0},
        '{32'sh7FFF_0000, SET_MIXED, 1'b0, 64'sh0, 1'b0}
    };

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_raw_value = '0;
    logic               o_valid;
    logic               i_stall     = 1'b0;
    logic signed [63:0] o_converted_value;
    logic               o_saturated;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic        [4:0]  paddr       = '0;
    logic        [31:0] pwdata      = '0;
    logic        [31:0] prdata;
    logic               pready;

    // Shadow of the register file
    pvc_pkg::t_count    model_count = pvc_pkg::COUNT_RESET;
    logic signed [31:0] model_coeff [pvc_pkg::NUM_COEFFS];
    pvc_pkg::t_count    next_count;
    logic signed [31:0] next_coeff [pvc_pkg::NUM_COEFFS];

    t_conv       pending_results [$];
    int          err_cnt     = 0;
    int          n_samples   = 0;
    int          n_sat       = 0;
    int          n_settings  = 1;
    int          idle_cycles = 0;
    int unsigned rx_gap      = 0;
    int          burst_left  = 0;
    bit          rx_long_hold = 1'b0;
    bit          quiet_mode   = 1'b0;

    polynomial_value_conversion dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_conv fx_mul(input logic signed [63:0] a, input logic signed [63:0] b);
        logic signed [127:0] wa, wb, p, hi_lim, lo_lim;
        t_conv r;
        wa = a;
        wb = b;
        hi_lim = pvc_pkg::SAT_MAX;
        lo_lim = pvc_pkg::SAT_MIN;
        p = (wa * wb) >>> FRAC_BITS;  // floor, as the shift is arithmetic
        if (p > hi_lim) r = '{pvc_pkg::SAT_MAX, 1'b1};
        else if (p < lo_lim) r = '{pvc_pkg::SAT_MIN, 1'b1};
        else r = '{p[63:0], 1'b0};
        return r;
    endfunction

    function automatic t_conv fx_add(input logic signed [63:0] a, input logic signed [63:0] b);
        logic signed [64:0] wa, wb, s, hi_lim, lo_lim;
        t_conv r;
        wa = a;
        wb = b;
        hi_lim = pvc_pkg::SAT_MAX;
        lo_lim = pvc_pkg::SAT_MIN;
        s = wa + wb;
        if (s > hi_lim) r = '{pvc_pkg::SAT_MAX, 1'b1};
        else if (s < lo_lim) r = '{pvc_pkg::SAT_MIN, 1'b1};
        else r = '{s[63:0], 1'b0};
        return r;
    endfunction

    // Power-sum evaluation: power *= x, then acc += c_k * power
    function automatic t_conv convert_sample(input logic signed [31:0] x);
        logic signed [63:0] pw, acc, xw;
        t_conv step;
        logic ovf;
        int n;
        n = (model_count == 0) ? 1 : int'(model_count);
        if (n > MAX_TERMS) n = MAX_TERMS;
        pw = 64'sd1 <<< FRAC_BITS;
        acc = model_coeff[0];
        xw = x;
        ovf = 1'b0;
        for (int k = 1; k < n; k++) begin
            step = fx_mul(pw, xw);
            pw = step.value;
            ovf |= step.sat;
            step = fx_mul(model_coeff[k], pw);
            ovf |= step.sat;
            step = fx_add(acc, step.value);
            acc = step.value;
            ovf |= step.sat;
        end
        return t_conv'{acc, ovf};
    endfunction

    function automatic logic signed [31:0] edge_value(input int unsigned sel);
        case (sel)
            0: return '0;
            1: return 32'sd1;
            2: return -32'sd1;
            3: return pvc_pkg::COEFF_ONE;
            4: return -pvc_pkg::COEFF_ONE;
            5: return C_MAX;
            default: return C_MIN;
        endcase
    endfunction

    // Mostly moderate magnitudes so long polynomials stay out of saturation
    function automatic logic signed [31:0] rand_raw();
        logic signed [31:0] r;
        r = $signed($urandom);
        case ($urandom_range(0, 9))
            0, 1: return r;
            2: return edge_value($urandom_range(0, 6));
            3, 4, 5: return r >>> 13;
            default: return r >>> 8;
        endcase
    endfunction

    task automatic flag_mismatch(input string what);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS) $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic apb_access(input pvc_pkg::t_reg_idx idx, input logic is_write,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes next_count / next_coeff, then reads every register back
    task automatic program_coeffs();
        logic [31:0] wdata, rdata;
        wdata = $urandom;
        wdata[2:0] = next_count;
        apb_access(pvc_pkg::REG_COEFF_COUNT, 1'b1, wdata, rdata);
        model_count = next_count;
        for (int k = 0; k < pvc_pkg::NUM_COEFFS; k++) begin
            apb_access(pvc_pkg::t_reg_idx'(pvc_pkg::REG_COEFF_0 + k), 1'b1,
                       next_coeff[k], rdata);
            model_coeff[k] = next_coeff[k];
        end
        apb_access(pvc_pkg::REG_COEFF_COUNT, 1'b0, '0, rdata);
        if (rdata !== {29'd0, model_count})
            flag_mismatch($sformatf("coeff_count reads %0h, expected %0h", rdata, model_count));
        for (int k = 0; k < pvc_pkg::NUM_COEFFS; k++) begin
            apb_access(pvc_pkg::t_reg_idx'(pvc_pkg::REG_COEFF_0 + k), 1'b0, '0, rdata);
            if (rdata !== model_coeff[k])
                flag_mismatch($sformatf("coeff_%0d reads %h, expected %h",
                                        k, rdata, model_coeff[k]));
        end
        n_settings++;
    endtask

    task automatic load_coeff_set(input t_coeff_set sel);
        for (int k = 0; k < pvc_pkg::NUM_COEFFS; k++) next_coeff[k] = '0;
        case (sel)
            SET_COUNT_ZERO: begin
                next_count = 3'd0;
                next_coeff[0] = C_MIN;
                for (int k = 1; k < pvc_pkg::NUM_COEFFS; k++) next_coeff[k] = C_MAX;
            end
            SET_CONST_ONLY: begin
                next_count = 3'd1;
                next_coeff[0] = C_MAX;
                for (int k = 1; k < pvc_pkg::NUM_COEFFS; k++) next_coeff[k] = C_MIN;
            end
            SET_ALL_MAX: begin
                next_count = 3'd7;
                for (int k = 0; k < pvc_pkg::NUM_COEFFS; k++) next_coeff[k] = C_MAX;
            end
            SET_ALL_MIN: begin
                next_count = 3'd7;
                for (int k = 0; k < pvc_pkg::NUM_COEFFS; k++) next_coeff[k] = C_MIN;
            end
            SET_MIXED: begin
                // -1.5 + 0.5x - 0.25x^2 + 2x^3
                next_count = 3'd4;
                next_coeff[0] = 32'shFFFE_8000;
                next_coeff[1] = 32'sh0000_8000;
                next_coeff[2] = 32'shFFFF_C000;
                next_coeff[3] = 32'sh0002_0000;
            end
            default: begin
                next_count = pvc_pkg::COUNT_RESET;
                next_coeff[1] = pvc_pkg::COEFF_ONE;
            end
        endcase
        program_coeffs();
    endtask

    task automatic send_sample(input logic signed [31:0] x, input t_conv want);
        int unsigned gap;
        gap = (quiet_mode || burst_left > 0) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_raw_value <= x;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        pending_results.push_back(want);
        n_samples++;
        if (burst_left > 0) burst_left--;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Output side: per-beat random stall, or one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_long_hold) begin
                rx_long_hold = 1'b0;
                rx_gap = HOLD_CYCLES;
            end else if (o_valid && !i_stall) begin
                rx_gap = quiet_mode ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (rx_gap > 0) begin
                i_stall <= 1'b1;
                rx_gap--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_conv want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (o_saturated === 1'b1) n_sat++;
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("result %h with nothing outstanding",
                                        o_converted_value));
            end else begin
                want = pending_results.pop_front();
                if (o_converted_value !== want.value)
                    flag_mismatch($sformatf("converted_value %h, expected %h",
                                            o_converted_value, want.value));
                if (o_saturated !== want.sat)
                    flag_mismatch($sformatf("saturated %b, expected %b",
                                            o_saturated, want.sat));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        t_conv              want;
        t_coeff_set         cur_set;
        logic signed [31:0] x;
        for (int k = 0; k < pvc_pkg::NUM_COEFFS; k++) model_coeff[k] = '0;
        model_coeff[1] = pvc_pkg::COEFF_ONE;
        cur_set = SET_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows start on the reset register values
        for (int r = 0; r < NUM_DIR; r++) begin
            if (DIR_ROWS[r].coeffs != cur_set) begin
                wait_drained();
                load_coeff_set(DIR_ROWS[r].coeffs);
                cur_set = DIR_ROWS[r].coeffs;
            end
            if (DIR_ROWS[r].typed) want = '{DIR_ROWS[r].want_value, DIR_ROWS[r].want_sat};
            else want = convert_sample(DIR_ROWS[r].raw);
            send_sample(DIR_ROWS[r].raw, want);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained();
            if (ph == 0) next_count = 3'd7;
            else if (ph == 1) next_count = 3'd0;
            else next_count = pvc_pkg::t_count'($urandom_range(0, 7));
            for (int k = 0; k < pvc_pkg::NUM_COEFFS; k++) begin
                case ($urandom_range(0, 3))
                    0: next_coeff[k] = $urandom;
                    1: next_coeff[k] = edge_value($urandom_range(0, 6));
                    default: next_coeff[k] = $signed($urandom) >>> 12;
                endcase
            end
            program_coeffs();
            quiet_mode = (ph % 4 == 3);
            for (int s = 0; s < PHASE_ITEMS; s++) begin
                // receiver holds off while beats keep coming, so the chain backs up
                if (ph == 2 && s == 10) begin
                    rx_long_hold = 1'b1;
                    burst_left = 60;
                end
                if (ph == 5 && s == 60) wait_drained();
                x = rand_raw();
                send_sample(x, convert_sample(x));
            end
            quiet_mode = 1'b0;
        end

        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Converted %0d samples under %0d coefficient settings, %0d saturating;",
                 n_samples, n_settings, n_sat);
        $display("random gaps, a long output hold-off and full drains; %0d mismatches.",
                 err_cnt);
        if (err_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pvc_pkg.sv
rtl/pvc_mul.sv
rtl/pvc_term.sv
rtl/polynomial_value_conversion.sv
tb/tb_polynomial_value_conversion.sv
